// ----- rtl/core/csc_pkg.sv -----
package csc_pkg;

  localparam int DATA_W = 32;
  localparam int STORE_W = 48;
  localparam int WIDE_W = 64;
  localparam int DEN_W = 49;
  localparam int PIDX_W = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_COUNT = 1'b1;

  localparam logic [DATA_W-1:0] STEP_SIZE_RESET = 32'h0001_0000;
  localparam logic [5:0] INTERVAL_COUNT_RESET = 6'd63;

  // pivots are Q24
  localparam logic signed [STORE_W-1:0] PIV_FOUR = 48'sh0000_0400_0000;
  localparam logic signed [STORE_W-1:0] PIV_MONE = 48'shFFFF_FF00_0000;
  localparam logic signed [WIDE_W-1:0] PIV_ONE_SQ = 64'sh0001_0000_0000_0000;
  localparam logic signed [DEN_W-1:0] DEN_SIX = 49'sd6;

  localparam logic signed [WIDE_W-1:0] CAP47 = 64'sh0000_8000_0000_0000;
  localparam logic signed [WIDE_W-1:0] NEG_CAP47 = 64'shFFFF_8000_0000_0000;
  localparam logic signed [WIDE_W-1:0] DIVIDEND_LIM = 64'sh0000_003F_FFFF_FFFF;

  typedef struct packed {
    logic go;
    logic signed [WIDE_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [WIDE_W-1:0] quo;
  } div_resp_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic clip;
  } sat_t;

  // dividend of a pivot division: clamp then scale by 2^24
  function automatic logic signed [WIDE_W-1:0] piv_num(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] c;
    begin
      if (x > DIVIDEND_LIM) c = DIVIDEND_LIM;
      else if (x < -DIVIDEND_LIM) c = -DIVIDEND_LIM;
      else c = x;
      piv_num = c <<< 24;
    end
  endfunction

  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    begin
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
        r.val = 32'sh7FFF_FFFF;
        r.clip = 1'b1;
      end else if (v < 64'shFFFF_FFFF_8000_0000) begin
        r.val = 32'sh8000_0000;
        r.clip = 1'b1;
      end else begin
        r.val = v[DATA_W-1:0];
        r.clip = 1'b0;
      end
      sat32 = r;
    end
  endfunction

endpackage

// ----- rtl/core/csc_if.sv -----
interface csc_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] sample_value;
  logic last_sample;
  modport source (output valid, sample_value, last_sample, input ready);
  modport sink (input valid, sample_value, last_sample, output ready);
endinterface

interface csc_out_if;
  logic valid;
  logic ready;
  logic [5:0] point_index;
  logic signed [31:0] coef_linear;
  logic signed [31:0] coef_quadratic;
  logic signed [31:0] coef_cubic;
  logic last_point;
  logic saturated;
  modport source (output valid, point_index, coef_linear, coef_quadratic, coef_cubic,
                  last_point, saturated, input ready);
  modport sink (input valid, point_index, coef_linear, coef_quadratic, coef_cubic,
                last_point, saturated, output ready);
endinterface

// ----- rtl/core/csc_ram.sv -----
module csc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/csc_div.sv -----
module csc_div (
  input  logic clk,
  input  logic rst,
  input  csc_pkg::div_req_t req,
  output csc_pkg::div_resp_t resp
);
  import csc_pkg::*;

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_PREP = 4'b0010,
    D_ITER = 4'b0100,
    D_FIN  = 4'b1000
  } dstate_t;

  dstate_t state;
  logic [WIDE_W-1:0] nm;
  logic [DEN_W-1:0] dm;
  logic [DEN_W-1:0] rem;
  logic [5:0] cnt;
  logic neg;
  logic zero;
  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] rem_diff;
  logic take;

  assign rem_sh = {rem, nm[WIDE_W-1]};
  assign rem_diff = rem_sh - {1'b0, dm};
  assign take = (rem_sh >= {1'b0, dm});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      resp.done <= 1'b0;
    end else begin
      resp.done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (req.go) begin
            nm <= req.num[WIDE_W-1] ? WIDE_W'(-req.num) : WIDE_W'(req.num);
            dm <= req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
            neg <= req.num[WIDE_W-1] ^ req.den[DEN_W-1];
            zero <= (req.den == '0);
            state <= D_PREP;
          end
        end
        D_PREP: begin
          // half the divisor gives round half away from zero
          nm <= nm + WIDE_W'(dm >> 1);
          rem <= '0;
          cnt <= '0;
          state <= D_ITER;
        end
        D_ITER: begin
          rem <= take ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          nm <= {nm[WIDE_W-2:0], take};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= D_FIN;
        end
        D_FIN: begin
          if (zero) resp.quo <= '0;
          else if (neg) resp.quo <= -$signed(nm);
          else resp.quo <= $signed(nm);
          resp.done <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/core/cubic_spline_coefficients.sv -----
// Cubic spline coefficient unit: while idle, samples y[0..n] load one per cycle on the
// samples channel; the sample marked last starts a run that solves the spline system and
// delivers one result per point 0..n (b, c, d saturated to Q16.16). A mark with the wrong
// sample count drops the run and clears the count. All divisions go through one shared
// radix-2 divider; a run forms the second differences, then makes up to
// (2 + 2n + n+1 + 6(n+1)) divisions, and samples are not accepted meanwhile. Registers are
// sampled at the marked sample.
module cubic_spline_coefficients #(
  parameter int MAX_POINTS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [csc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csc_pkg::DATA_W-1:0] cfg_data,
  csc_in_if.sink samples,
  csc_out_if.source coefs
);
  import csc_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 2);
  localparam int NMAX = MAX_POINTS - 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);

  typedef enum logic [26:0] {
    S_IDLE   = 27'd1 << 0,
    S_D_RD   = 27'd1 << 1,
    S_D_USE  = 27'd1 << 2,
    S_R0     = 27'd1 << 3,
    S_R0W    = 27'd1 << 4,
    S_RNW    = 27'd1 << 5,
    S_F_RD   = 27'd1 << 6,
    S_F_PIV  = 27'd1 << 7,
    S_F_A    = 27'd1 << 8,
    S_F_B    = 27'd1 << 9,
    S_B_N    = 27'd1 << 10,
    S_B_NW   = 27'd1 << 11,
    S_B_RD   = 27'd1 << 12,
    S_B_GO   = 27'd1 << 13,
    S_B_W    = 27'd1 << 14,
    S_O_INIT = 27'd1 << 15,
    S_O_I2   = 27'd1 << 16,
    S_O_RD   = 27'd1 << 17,
    S_O_LD   = 27'd1 << 18,
    S_O_B    = 27'd1 << 19,
    S_O_C1   = 27'd1 << 20,
    S_O_C2   = 27'd1 << 21,
    S_O_D1   = 27'd1 << 22,
    S_O_D2   = 27'd1 << 23,
    S_O_D3   = 27'd1 << 24,
    S_O_EM   = 27'd1 << 25,
    S_DIV    = 27'd1 << 26
  } state_t;

  state_t state, ret_state;

  logic [DATA_W-1:0] step_size;
  logic [5:0] interval_count;
  logic [CW-1:0] load_count;
  logic [IW-1:0] idx, n_reg;
  logic [DATA_W-1:0] h_reg;

  logic signed [DATA_W-1:0] yb_w, yc_w, ya, yb;
  logic signed [35:0] d2_1, d2_2, d2_l1, d2_l2;
  logic signed [STORE_W-1:0] rraw, dnew, diag_prev;
  logic signed [WIDE_W-1:0] rhs_prev, u_next, ua, ub, bres, cres, dq;
  logic endp, scl;

  div_req_t div_req;
  div_resp_t div_resp;

  // memories
  logic s_we, r_we, g_we, c_we;
  logic [IW-1:0] s_wa, r_wa, g_wa, c_wa;
  logic [DATA_W-1:0] s_wd, s_rd;
  logic [STORE_W-1:0] r_wd, g_wd, c_wd, r_rd, g_rd, c_rd;

  csc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_sample (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(idx), .rdata(s_rd));
  csc_ram #(.WIDTH(STORE_W), .DEPTH(MAX_POINTS)) u_rhs (
    .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(idx), .rdata(r_rd));
  csc_ram #(.WIDTH(STORE_W), .DEPTH(MAX_POINTS)) u_diag (
    .clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(idx), .rdata(g_rd));
  csc_ram #(.WIDTH(STORE_W), .DEPTH(MAX_POINTS)) u_cubic (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(idx), .rdata(c_rd));

  csc_div u_div (.clk(clk), .rst(rst), .req(div_req), .resp(div_resp));

  // load side
  logic in_acc;
  logic [CW-1:0] cnt_inc;
  logic [IW-1:0] n_clamp;

  assign samples.ready = (state == S_IDLE);
  assign in_acc = samples.valid && samples.ready;
  assign cnt_inc = (load_count <= CNT_MAX) ? load_count + CW'(1) : load_count;

  always_comb begin
    if (interval_count < 6'd3) n_clamp = IW'(3);
    else if (32'(interval_count) > 32'(NMAX)) n_clamp = IW'(NMAX);
    else n_clamp = IW'(interval_count);
  end

  // datapath terms
  logic signed [35:0] d2;
  logic signed [WIDE_W-1:0] rhs_new, dy, bnum, u_self, dv;

  assign d2 = 36'($signed(s_rd)) - (36'(yc_w) <<< 1) + 36'(yb_w);
  assign rhs_new = WIDE_W'(rraw) - dq;
  assign dy = WIDE_W'(yb) - WIDE_W'(ya);
  assign bnum = endp ? dy + (ua + (ub <<< 1)) : dy - (ub + (ua <<< 1));
  assign u_self = endp ? ub : ua;
  assign dv = ub - ua;

  // divider calls
  logic call_en, call_scl;
  logic signed [WIDE_W-1:0] call_num;
  logic signed [DEN_W-1:0] call_den, h_den;
  state_t call_ret;

  assign h_den = DEN_W'({1'b0, h_reg});

  always_comb begin
    call_en = 1'b1;
    call_scl = 1'b0;
    call_num = '0;
    call_den = h_den;
    call_ret = S_IDLE;
    case (state)
      S_R0: begin
        call_num = WIDE_W'(d2_2 - d2_1);
        call_den = DEN_SIX;
        call_ret = S_R0W;
      end
      S_R0W: begin
        call_num = WIDE_W'(d2_l1 - d2_l2);
        call_den = DEN_SIX;
        call_ret = S_RNW;
      end
      S_F_PIV: begin
        call_num = PIV_ONE_SQ;
        call_den = DEN_W'(diag_prev);
        call_ret = S_F_A;
      end
      S_F_A: begin
        call_num = piv_num(rhs_prev);
        call_den = DEN_W'(diag_prev);
        call_ret = S_F_B;
      end
      S_B_N: begin
        call_num = piv_num(rhs_prev);
        call_den = DEN_W'(diag_prev);
        call_ret = S_B_NW;
      end
      S_B_GO: begin
        call_num = piv_num(WIDE_W'($signed(r_rd)) - u_next);
        call_den = DEN_W'($signed(g_rd));
        call_ret = S_B_W;
      end
      S_O_B: begin
        call_scl = 1'b1;
        call_num = bnum;
        call_ret = S_O_C1;
      end
      S_O_C1: begin
        call_scl = 1'b1;
        call_num = u_self + (u_self <<< 1);
        call_ret = S_O_C2;
      end
      S_O_C2: begin
        call_scl = 1'b1;
        call_num = dq;
        call_ret = S_O_D1;
      end
      S_O_D1: begin
        call_scl = 1'b1;
        call_num = dv;
        call_ret = S_O_D2;
      end
      S_O_D2: begin
        call_scl = 1'b1;
        call_num = dq;
        call_ret = S_O_D3;
      end
      S_O_D3: begin
        call_scl = 1'b1;
        call_num = dq;
        call_ret = S_O_EM;
      end
      default: call_en = 1'b0;
    endcase
  end

  // memory writes
  always_comb begin
    s_we = in_acc && (load_count < CNT_MAX);
    s_wa = load_count[IW-1:0];
    s_wd = samples.sample_value;
    r_we = 1'b0;
    r_wa = idx;
    r_wd = rhs_new[STORE_W-1:0];
    g_we = 1'b0;
    g_wa = idx;
    g_wd = dnew;
    c_we = 1'b0;
    c_wa = idx;
    c_wd = dq[STORE_W-1:0];
    case (state)
      S_D_USE: begin
        r_we = (idx >= IW'(2));
        r_wa = idx - IW'(1);
        r_wd = STORE_W'(d2);
      end
      S_R0W: begin
        r_we = 1'b1;
        r_wa = '0;
        r_wd = dq[STORE_W-1:0];
        g_we = 1'b1;
        g_wa = '0;
        g_wd = PIV_MONE;
      end
      S_RNW: begin
        r_we = 1'b1;
        r_wa = n_reg;
        r_wd = STORE_W'(-dq);
      end
      S_F_B: begin
        r_we = 1'b1;
        g_we = 1'b1;
      end
      S_B_NW: begin
        c_we = 1'b1;
        c_wa = n_reg;
      end
      S_B_W: c_we = 1'b1;
      default: ;
    endcase
  end

  // result register
  logic out_valid;
  logic out_free;
  sat_t sb, sc, sd;

  assign out_free = !out_valid || coefs.ready;
  assign coefs.valid = out_valid;
  assign sb = sat32(bres);
  assign sc = sat32(cres);
  assign sd = sat32(dq);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_O_EM && out_free) begin
      out_valid <= 1'b1;
      coefs.point_index <= endp ? 6'(n_reg) : 6'(idx - IW'(1));
      coefs.coef_linear <= sb.val;
      coefs.coef_quadratic <= sc.val;
      coefs.coef_cubic <= sd.val;
      coefs.last_point <= endp;
      coefs.saturated <= sb.clip | sc.clip | sd.clip;
    end else if (coefs.ready) begin
      out_valid <= 1'b0;
    end
  end

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= STEP_SIZE_RESET;
      interval_count <= INTERVAL_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STEP_SIZE: step_size <= cfg_data;
        REG_INTERVAL_COUNT: interval_count <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      load_count <= '0;
      div_req.go <= 1'b0;
    end else begin
      div_req.go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (samples.last_sample) begin
              load_count <= '0;
              if (cnt_inc == CW'(n_clamp) + CW'(1)) begin
                n_reg <= n_clamp;
                h_reg <= (step_size == '0) ? 32'd1 : step_size;
                idx <= '0;
                state <= S_D_RD;
              end
            end else begin
              load_count <= cnt_inc;
            end
          end
        end
        S_D_RD: state <= S_D_USE;
        S_D_USE: begin
          yb_w <= yc_w;
          yc_w <= $signed(s_rd);
          if (idx >= IW'(2)) begin
            d2_l2 <= d2_l1;
            d2_l1 <= d2;
          end
          if (idx == IW'(2)) d2_1 <= d2;
          if (idx == IW'(3)) d2_2 <= d2;
          if (idx == n_reg) begin
            state <= S_R0;
          end else begin
            idx <= idx + IW'(1);
            state <= S_D_RD;
          end
        end
        S_R0W: rhs_prev <= dq;
        S_RNW: begin
          diag_prev <= PIV_MONE;
          idx <= IW'(1);
          state <= S_F_RD;
        end
        S_F_RD: state <= S_F_PIV;
        S_F_PIV: rraw <= $signed(r_rd);
        S_F_A: dnew <= ((idx < n_reg) ? PIV_FOUR : PIV_MONE) - dq[STORE_W-1:0];
        S_F_B: begin
          rhs_prev <= rhs_new;
          diag_prev <= dnew;
          if (idx == n_reg) begin
            state <= S_B_N;
          end else begin
            idx <= idx + IW'(1);
            state <= S_F_RD;
          end
        end
        S_B_NW: begin
          u_next <= dq;
          idx <= n_reg - IW'(1);
          state <= S_B_RD;
        end
        S_B_RD: state <= S_B_GO;
        S_B_W: begin
          u_next <= dq;
          if (idx == '0) begin
            state <= S_O_INIT;
          end else begin
            idx <= idx - IW'(1);
            state <= S_B_RD;
          end
        end
        S_O_INIT: begin
          endp <= 1'b0;
          state <= S_O_I2;
        end
        S_O_I2: begin
          ya <= $signed(s_rd);
          ua <= WIDE_W'($signed(c_rd));
          idx <= IW'(1);
          state <= S_O_RD;
        end
        S_O_RD: state <= S_O_LD;
        S_O_LD: begin
          yb <= $signed(s_rd);
          ub <= WIDE_W'($signed(c_rd));
          state <= S_O_B;
        end
        S_O_C1: bres <= dq;
        S_O_D1: cres <= dq;
        S_O_EM: begin
          if (out_free) begin
            if (endp) begin
              state <= S_IDLE;
            end else if (idx == n_reg) begin
              endp <= 1'b1;
              state <= S_O_B;
            end else begin
              ya <= yb;
              ua <= ub;
              idx <= idx + IW'(1);
              state <= S_O_RD;
            end
          end
        end
        S_DIV: begin
          if (div_resp.done) begin
            if (scl && (div_resp.quo > CAP47 || div_resp.quo < NEG_CAP47))
              dq <= div_resp.quo[WIDE_W-1] ? NEG_CAP47 : CAP47;
            else
              dq <= div_resp.quo;
            state <= ret_state;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (call_en) begin
        if (call_scl && (call_num >= CAP47 || call_num <= NEG_CAP47)) begin
          // too large to scale: result is the cap itself
          dq <= call_num[WIDE_W-1] ? NEG_CAP47 : CAP47;
          state <= call_ret;
        end else begin
          div_req.go <= 1'b1;
          div_req.num <= call_scl ? (call_num <<< 16) : call_num;
          div_req.den <= call_den;
          scl <= call_scl;
          ret_state <= call_ret;
          state <= S_DIV;
        end
      end
    end
  end
endmodule

// ----- rtl/core/csc_checker.sv -----
module csc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [5:0] out_index,
  input logic [31:0] out_b
);
  // a stalled beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_index) && $stable(out_b) && $stable(out_last))
    else $error("stalled result beat changed");

  // only a marked sample starts a run
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid && in_last))
    else $error("input stalled without a marked sample");

  // results before the last one are given only during a run
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("intermediate result outside a run");
endmodule

bind cubic_spline_coefficients csc_checker u_csc_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(samples.valid),
  .in_ready(samples.ready),
  .in_last(samples.last_sample),
  .out_valid(coefs.valid),
  .out_ready(coefs.ready),
  .out_last(coefs.last_point),
  .out_index(coefs.point_index),
  .out_b(coefs.coef_linear)
);

// ----- sim/cubic_spline_coefficients_tb.sv -----
`timescale 1ns / 1ps

module cubic_spline_coefficients_tb;
  import csc_pkg::*;

  localparam int NPTS = 64;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES = 6000;

  typedef struct {
    logic [5:0] idx;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    bit lastp;
    bit sat;
  } coef_t;

  class spline_coef_board;
    localparam longint PIV = 64'sd1 <<< 24;
    localparam longint unsigned CAP = 64'd1 << 47;
    localparam longint DLIM = (64'sd1 <<< 38) - 1;

    logic [31:0] step;
    logic [5:0] icount;
    longint ys[NPTS];
    longint diag[NPTS];
    longint rhs[NPTS];
    longint u[NPTS];
    int load_cnt;
    coef_t pending_coefs[$];
    int errors;

    function void clear();
      step = STEP_SIZE_RESET;
      icount = INTERVAL_COUNT_RESET;
      load_cnt = 0;
      errors = 0;
      pending_coefs.delete();
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function longint rdiv(longint num, longint den);
      longint unsigned m, dm, q;
      if (den == 0) return 0;
      m = mag(num);
      dm = mag(den);
      q = (m + dm / 2) / dm;
      return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function longint pdiv(longint x, longint p);
      if (x > DLIM) x = DLIM;
      if (x < -DLIM) x = -DLIM;
      return rdiv(x * PIV, p);
    endfunction

    function longint hdiv(longint x, longint unsigned h);
      longint unsigned m, q;
      m = mag(x);
      if (m >= CAP) q = CAP;
      else begin
        q = ((m << 16) + h / 2) / h;
        if (q > CAP) q = CAP;
      end
      return x < 0 ? -longint'(q) : longint'(q);
    endfunction

    function logic [31:0] clip32(longint v, inout bit clip);
      if (v > 64'sh7FFF_FFFF) begin
        clip = 1;
        return 32'h7FFF_FFFF;
      end
      if (v < -64'sh8000_0000) begin
        clip = 1;
        return 32'h8000_0000;
      end
      return v[31:0];
    endfunction

    function longint d2(int i);
      return ys[i + 1] - 2 * ys[i] + ys[i - 1];
    endfunction

    function void solve_spline(int n, longint unsigned h);
      longint bnum, dv;
      coef_t r;
      bit clip;
      rhs[0] = rdiv(d2(2) - d2(1), 6);
      for (int i = 1; i < n; i++) rhs[i] = d2(i);
      rhs[n] = -rdiv(d2(n - 1) - d2(n - 2), 6);
      diag[0] = -PIV;
      for (int i = 1; i <= n; i++) begin
        diag[i] = ((i < n) ? 4 * PIV : -PIV) - rdiv(PIV * PIV, diag[i - 1]);
        rhs[i] -= pdiv(rhs[i - 1], diag[i - 1]);
      end
      u[n] = pdiv(rhs[n], diag[n]);
      for (int i = n - 1; i >= 0; i--) u[i] = pdiv(rhs[i] - u[i + 1], diag[i]);
      for (int i = 0; i <= n; i++) begin
        clip = 0;
        if (i < n) begin
          bnum = (ys[i + 1] - ys[i]) - (u[i + 1] + 2 * u[i]);
          dv = u[i + 1] - u[i];
        end else begin
          bnum = (ys[n] - ys[n - 1]) + (u[n - 1] + 2 * u[n]);
          dv = u[n] - u[n - 1];
        end
        r.idx = i[5:0];
        r.b = clip32(hdiv(bnum, h), clip);
        r.c = clip32(hdiv(hdiv(3 * u[i], h), h), clip);
        r.d = clip32(hdiv(hdiv(hdiv(dv, h), h), h), clip);
        r.lastp = (i == n);
        r.sat = clip;
        pending_coefs.push_back(r);
      end
    endfunction

    function void note_sample(logic [31:0] raw, bit last);
      longint v;
      int n;
      v = $signed(raw);
      if (load_cnt < NPTS) ys[load_cnt] = v;
      if (load_cnt <= NPTS) load_cnt++;
      if (!last) return;
      n = icount;
      if (n < 3) n = 3;
      if (n > NPTS - 1) n = NPTS - 1;
      if (load_cnt != n + 1) begin
        load_cnt = 0;
        return;
      end
      load_cnt = 0;
      solve_spline(n, step != 0 ? longint'(step) : 64'd1);
    endfunction

    function void check_point(coef_t got);
      coef_t e;
      if (pending_coefs.size() == 0) begin
        errors++;
        $display("%0t: unexpected point %0d", $time, got.idx);
        return;
      end
      e = pending_coefs.pop_front();
      if (e.idx !== got.idx || e.b !== got.b || e.c !== got.c || e.d !== got.d ||
          e.lastp !== got.lastp || e.sat !== got.sat) begin
        errors++;
        $display("%0t: mismatch exp idx=%0d b=%h c=%h d=%h last=%b sat=%b",
                 $time, e.idx, e.b, e.c, e.d, e.lastp, e.sat,
                 " got idx=%0d b=%h c=%h d=%h last=%b sat=%b",
                 got.idx, got.b, got.c, got.d, got.lastp, got.sat);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  csc_in_if smp();
  csc_out_if cof();

  cubic_spline_coefficients uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .samples(smp),
    .coefs(cof)
  );

  spline_coef_board sb;
  int send_idle;
  int recv_stall;
  bit hold_req;
  int hold_left;
  int quiet_cycles;
  int phase_items;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog on accepted beats of either channel
  always @(posedge clk) begin
    if ((smp.valid && smp.ready) || (cof.valid && cof.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: check, then decide ready for the next edge
  initial begin
    coef_t got;
    cof.ready = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && cof.valid && cof.ready) begin
        got.idx = cof.point_index;
        got.b = cof.coef_linear;
        got.c = cof.coef_quadratic;
        got.d = cof.coef_cubic;
        got.lastp = cof.last_point;
        got.sat = cof.saturated;
        sb.check_point(got);
      end
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        cof.ready <= 1'b0;
      end else begin
        cof.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    // registers only change with the block idle
    smp.valid <= 1'b0;
    while (sb.pending_coefs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_STEP_SIZE) sb.step = val;
    else sb.icount = val[5:0];
  endtask

  task automatic send(logic [31:0] v, bit last);
    while ($urandom_range(99) < send_idle) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.sample_value <= v;
    smp.last_sample <= last;
    do @(posedge clk); while (!smp.ready);
    sb.note_sample(v, last);
    phase_items++;
  endtask

  function automatic logic [31:0] pick_sample(int style, int i, ref longint acc,
                                              ref longint slope);
    logic [31:0] edges[5];
    edges = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1};
    case (style)
      0: return $urandom;
      1: begin
        if (i == 0) begin
          acc = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
          slope = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
        end
        slope += $signed($urandom_range(0, 1 << 13)) - (1 << 12);
        acc += slope;
        return acc[31:0];
      end
      default: return $urandom_range(5) == 5 ? $urandom : edges[$urandom_range(4)];
    endcase
  endfunction

  task automatic run_seq(int cnt, bit mark, int style);
    longint acc, slope;
    logic [31:0] v;
    for (int i = 0; i < cnt; i++) begin
      v = pick_sample(style, i, acc, slope);
      send(v, mark && (i == cnt - 1));
    end
  endtask

  task automatic send_list(logic [31:0] vals[4]);
    for (int i = 0; i < 4; i++) send(vals[i], i == 3);
  endtask

  function automatic int eff_n();
    int n;
    n = sb.icount;
    return n < 3 ? 3 : n;
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 255);
      default: return $urandom_range(1 << 12, 1 << 20);
    endcase
  endfunction

  initial begin
    int n, k;
    sb = new();
    sb.clear();
    rst = 1;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    smp.valid = 0;
    smp.sample_value = '0;
    smp.last_sample = 0;
    send_idle = 0;
    recv_stall = 0;
    hold_req = 0;
    quiet_cycles = 0;
    phase_items = 0;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: field extremes, dropped mark, clamped count, step extremes
    write_reg(REG_INTERVAL_COUNT, 32'd3);
    send_list('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF});
    send_list('{32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0008_0000});
    send(32'h1234_5678, 1'b1);
    write_reg(REG_INTERVAL_COUNT, 32'hFFFF_FFC1);
    send_list('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    write_reg(REG_STEP_SIZE, 32'h0);
    send_list('{32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0300, 32'h0});
    write_reg(REG_STEP_SIZE, 32'hFFFF_FFFF);
    send_list('{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0});
    write_reg(REG_STEP_SIZE, 32'h1);
    send_list('{32'h0000_0001, 32'h0000_0003, 32'h0000_0002, 32'h0000_0007});

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_STEP_SIZE, pick_step());
      if (p == 5) write_reg(REG_INTERVAL_COUNT, 32'd63);
      else if ($urandom_range(4) == 0) write_reg(REG_INTERVAL_COUNT, $urandom_range(0, 2));
      else write_reg(REG_INTERVAL_COUNT, $urandom_range(3, 8));
      case (p % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 88; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 88; end
        default: begin send_idle = 19; recv_stall = 19; end
      endcase
      // long receiver hold while samples keep coming
      if (p == 2) hold_req = 1;
      // over-long load with no mark, then a mark: count saturates and the run drops
      if (p == 6) run_seq(NPTS + 2, 1'b1, 0);
      n = eff_n();
      phase_items = 0;
      while (phase_items < ((p == 5) ? 60 : 4)) begin
        k = $urandom_range(9);
        if (k < 8) run_seq(n + 1, 1'b1, $urandom_range(2));
        else if (k == 8) run_seq($urandom_range(1, n), 1'b1, 0);
        else run_seq($urandom_range(1, 3), 1'b0, 0);
      end
    end

    smp.valid <= 1'b0;
    while (sb.pending_coefs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
